### design/assert_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, sampled on clk, muted while rst_n is low.
`define UBF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication: when ante holds, cons must hold too.
`define UBF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  `UBF_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define UBF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  `UBF_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

### design/ubf_pkg.sv
// ----------------------------------------------------------------------------
// ubf_pkg
// Shared types and constants of the unique byte filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ubf_pkg;

  // One input transaction.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       has_byte;
    logic       end_of_string;
  } ubf_in_t;

  // One result transaction.
  typedef struct packed {
    logic [7:0] kept_byte;
    logic       kept_valid;
    logic       last_result;
    logic       overflowed;
  } ubf_out_t;

  // Occurrence table: one saturating count per byte value.
  localparam int unsigned TableDepth = 256;
  typedef logic [1:0] occ_t;
  localparam occ_t OccOnce = 2'd1;
  localparam occ_t OccMany = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // input transaction taken: latch it, read the table
    logic load_wr;  // write the updated count and buffer the byte
    logic set_ovf;  // byte dropped on a full buffer
    logic buf_rd;   // read the next buffered byte, advance the scan index
    logic tab_rd;   // look up the count of the byte just read
    logic keep;     // byte survives: emit the pending one, hold this one
    logic finish;   // emit the final result, clear the string state
  } ubf_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic buf_full;
    logic scan_done;
    logic is_single;
    logic pend_valid;
    logic out_free;
    logic end_q;
  } ubf_stat_t;

endpackage

`default_nettype wire

### design/ubf_stream_if.sv
// ----------------------------------------------------------------------------
// ubf_stream_if
// Valid/ready stream channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface ubf_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/unique_byte_filter_unit.sv
// ----------------------------------------------------------------------------
// unique_byte_filter_unit
// Removes every repeated byte from a string streamed in one byte at a time.
// ----------------------------------------------------------------------------
// Each byte is loaded by a read and a write-back: the occurrence table is a
// single-port memory, so the count is read in the accept cycle and written
// back in the next. The item that ends a string starts a replay of the
// buffer that takes each buffered byte through a buffer read, a table read
// and a check, then detects the end of the buffer and issues the last
// result; the replay can wait while the result side stalls. Results come
// out in string order; the last one is marked, and a string with no
// surviving byte yields a single result with kept_valid low. Up to MAX_LEN
// bytes are buffered; further bytes are dropped and flag every result of
// that string as overflowed. The table is emptied by clearing a bank of
// per-entry valid bits, so no clearing pass runs after reset or between
// strings. The next string may start loading while the last result still
// waits in the output register.
`default_nettype none

module unique_byte_filter_unit #(
  parameter int MAX_LEN = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ubf_stream_if.sink    in_i,
  ubf_stream_if.source  out_o
);
  import ubf_pkg::*;

  ubf_cmd_t  cmd;
  ubf_stat_t stat;
  ubf_in_t   in_data;
  ubf_out_t  out_data;
  logic      in_ready;
  logic      out_valid;

  assign in_data     = in_i.data;
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = out_data;

  // Sequence loads, the replay pass and result issue.
  ubf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_has_byte_i (in_data.has_byte),
    .in_end_i      (in_data.end_of_string),
    .in_ready_o    (in_ready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // Hold the buffer, the counts and the result register.
  ubf_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_data_o  (out_data),
    .out_ready_i (out_o.ready)
  );

endmodule

`default_nettype wire

### design/ubf_ctrl.sv
// ----------------------------------------------------------------------------
// ubf_ctrl
// Sequencer: loads bytes, then replays the buffer and issues the results.
// ----------------------------------------------------------------------------
`default_nettype none

module ubf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_has_byte_i,
  input  logic              in_end_i,
  output logic              in_ready_o,
  input  ubf_pkg::ubf_stat_t stat_i,
  output ubf_pkg::ubf_cmd_t  cmd_o
);
  import ubf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_LOAD     = 6'b000010,
    S_SCAN_RD  = 6'b000100,
    S_SCAN_TAB = 6'b001000,
    S_SCAN_CHK = 6'b010000,
    S_FINISH   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (in_has_byte_i && !stat_i.buf_full) begin
            state_d = S_LOAD;
          end else begin
            cmd_o.set_ovf = in_has_byte_i;
            state_d       = in_end_i ? S_SCAN_RD : S_IDLE;
          end
        end
      end
      S_LOAD: begin
        cmd_o.load_wr = 1'b1;
        state_d       = stat_i.end_q ? S_SCAN_RD : S_IDLE;
      end
      S_SCAN_RD: begin
        if (stat_i.scan_done) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.buf_rd = 1'b1;
          state_d      = S_SCAN_TAB;
        end
      end
      S_SCAN_TAB: begin
        cmd_o.tab_rd = 1'b1;
        state_d      = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        priority if (!stat_i.is_single) begin
          state_d = S_SCAN_RD;
        end else if (stat_i.pend_valid && !stat_i.out_free) begin
          state_d = S_SCAN_CHK;
        end else begin
          cmd_o.keep = 1'b1;
          state_d    = S_SCAN_RD;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### design/ubf_datapath.sv
// ----------------------------------------------------------------------------
// ubf_datapath
// Byte buffer, occurrence table, scan index and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ubf_datapath #(
  parameter int MAX_LEN = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ubf_pkg::ubf_cmd_t  cmd_i,
  output ubf_pkg::ubf_stat_t stat_o,
  input  ubf_pkg::ubf_in_t   in_data_i,
  output logic               out_valid_o,
  output ubf_pkg::ubf_out_t  out_data_o,
  input  logic               out_ready_i
);
  import ubf_pkg::*;

  localparam int CntW = $clog2(MAX_LEN + 1);
  localparam int IdxW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  // String state
  logic [CntW-1:0]       count_q, idx_q;
  logic                  ovf_q;
  logic                  end_q;
  logic [7:0]            byte_q;

  // Byte buffer and its registered read port
  logic [7:0]            buf_mem [MAX_LEN];
  logic [7:0]            bufdata_q;

  // Occurrence table with per-entry valid bits
  occ_t                  occ_mem [TableDepth];
  logic [TableDepth-1:0] occ_valid_q;
  occ_t                  occ_rd_q;
  logic                  occ_rd_valid_q;
  logic [7:0]            occ_addr;
  occ_t                  occ_cur, occ_new;

  // Pending survivor and result register
  logic                  pend_valid_q;
  logic [7:0]            pend_q;
  logic                  out_valid_q;
  ubf_out_t              out_q;
  logic                  out_free;
  logic                  emit_mid;

  assign occ_addr = cmd_i.accept ? in_data_i.byte_value : bufdata_q;
  assign occ_cur  = occ_rd_valid_q ? occ_rd_q : '0;
  assign occ_new  = (occ_cur == OccMany) ? OccMany : occ_t'(occ_cur + 2'd1);
  assign out_free = !out_valid_q || out_ready_i;
  assign emit_mid = cmd_i.keep && pend_valid_q;

  assign stat_o.buf_full   = (count_q == CntW'(MAX_LEN));
  assign stat_o.scan_done  = (idx_q == count_q);
  assign stat_o.is_single  = occ_rd_valid_q && (occ_rd_q == OccOnce);
  assign stat_o.pend_valid = pend_valid_q;
  assign stat_o.out_free   = out_free;
  assign stat_o.end_q      = end_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Table memory: one write or one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) begin
      occ_mem[byte_q] <= occ_new;
    end
    if (cmd_i.accept || cmd_i.tab_rd) begin
      occ_rd_q       <= occ_mem[occ_addr];
      occ_rd_valid_q <= occ_valid_q[occ_addr];
    end
  end

  // Buffer memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) begin
      buf_mem[count_q[IdxW-1:0]] <= byte_q;
    end
    if (cmd_i.buf_rd) begin
      bufdata_q <= buf_mem[idx_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= in_data_i.byte_value;
    end
    if (cmd_i.keep) begin
      pend_q <= bufdata_q;
    end
    if (cmd_i.finish) begin
      out_q <= '{kept_byte:   pend_valid_q ? pend_q : 8'd0,
                 kept_valid:  pend_valid_q,
                 last_result: 1'b1,
                 overflowed:  ovf_q};
    end else if (emit_mid) begin
      out_q <= '{kept_byte: pend_q, kept_valid: 1'b1, last_result: 1'b0,
                 overflowed: ovf_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      idx_q        <= '0;
      ovf_q        <= 1'b0;
      end_q        <= 1'b0;
      occ_valid_q  <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        end_q <= in_data_i.end_of_string;
      end
      if (cmd_i.set_ovf) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.load_wr) begin
        count_q              <= count_q + CntW'(1);
        occ_valid_q[byte_q]  <= 1'b1;
      end
      if (cmd_i.buf_rd) begin
        idx_q <= idx_q + CntW'(1);
      end
      if (cmd_i.keep) begin
        pend_valid_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        count_q      <= '0;
        idx_q        <= '0;
        ovf_q        <= 1'b0;
        occ_valid_q  <= '0;
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.finish || emit_mid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### design/ubf_checker.sv
// ----------------------------------------------------------------------------
// ubf_checker
// Port-level checks on the result stream of the unique byte filter.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ubf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_kept_byte_i,
  input logic       out_kept_valid_i,
  input logic       out_last_result_i,
  input logic       out_overflowed_i
);

  `UBF_ASSERT_NEXT(a_out_valid_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped before transaction")
  `UBF_ASSERT_NEXT(a_out_data_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_kept_byte_i) && $stable(out_kept_valid_i) && $stable(out_last_result_i) && $stable(out_overflowed_i), "stalled result changed")
  `UBF_ASSERT_IMPL(a_empty_is_last, clk_i, rst_ni, out_valid_i && !out_kept_valid_i, out_last_result_i, "empty result not marked last")
  `UBF_ASSERT_IMPL(a_empty_is_zero, clk_i, rst_ni, out_valid_i && !out_kept_valid_i, out_kept_byte_i == 8'd0, "empty result carries a byte")

endmodule

bind unique_byte_filter_unit ubf_checker u_ubf_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_kept_byte_i   (out_o.data.kept_byte),
  .out_kept_valid_i  (out_o.data.kept_valid),
  .out_last_result_i (out_o.data.last_result),
  .out_overflowed_i  (out_o.data.overflowed)
);

`default_nettype wire
